[hdl/sf_pkg.sv]
// ============================================================================
// sf_pkg - shared types and constants for the substring finder
// Item structs, configuration register codes, size defaults and the
// needle byte lookup used by the compare window.
// ============================================================================
package sf_pkg;

	// Size defaults, handed to the top level parameters
	localparam int NEEDLE_MAX_DEF   = 16;
	localparam int HAYSTACK_MAX_DEF = 65536;

	// Fixed field widths
	localparam int CFG_W   = 64;
	localparam int LEN_W   = 5;
	localparam int POS_W   = 16;
	localparam logic [POS_W-1:0] POS_CAP = 16'hFFFF;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_NEEDLE_LOW  = 2'd0,
		REG_NEEDLE_HIGH = 2'd1,
		REG_NEEDLE_LEN  = 2'd2
	} cfg_reg_t;

	// Input item: one haystack byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} sf_in_t;

	// Result item
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start_position;
	} sf_out_t;

	// Step control from the input stage to the window and result logic
	typedef struct packed {
		logic       fire;
		logic       last_byte;
		logic [7:0] data_byte;
	} sf_step_t;

	// Needle byte j; bytes beyond the two registers read as zero
	function automatic logic [7:0] needle_at(input logic [CFG_W-1:0] lo,
	                                         input logic [CFG_W-1:0] hi,
	                                         input int j);
		logic [7:0] b;
		b = 8'd0;
		if (j < 8) begin
			b = lo[8*j +: 8];
		end else if (j < 16) begin
			b = hi[8*(j-8) +: 8];
		end
		return b;
	endfunction

endpackage

[hdl/sf_window.sv]
// ============================================================================
// sf_window - byte history and parallel needle compare
// Holds the previous NEEDLE_MAX-1 bytes; with the current byte they form
// the window that is compared against the needle, aligned to its length.
// ============================================================================
module sf_window import sf_pkg::*; #(
	parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
	input  logic             clk,
	input  sf_step_t         step,
	input  logic [CFG_W-1:0] needle_low,
	input  logic [CFG_W-1:0] needle_high,
	input  logic [LEN_W-1:0] needle_len,
	output logic             window_eq
);

	localparam int HD   = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;
	localparam int IDXW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [7:0] hist_q [HD];
	logic [7:0] win [NEEDLE_MAX];
	logic [5:0] ago;
	logic       eq;

	// History shift: entry 0 is the newest byte
	always_ff @(posedge clk) begin
		if (step.fire) begin
			hist_q[0] <= step.data_byte;
			for (int k = 1; k < HD; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	// Window entry k is the byte k steps back; needle byte j sits len-1-j back
	always_comb begin
		eq  = 1'b1;
		ago = '0;
		win[0] = step.data_byte;
		for (int k = 1; k < NEEDLE_MAX; k++) begin
			win[k] = hist_q[k-1];
		end
		for (int j = 0; j < NEEDLE_MAX; j++) begin
			if (6'(j) < {1'b0, needle_len}) begin
				ago = {1'b0, needle_len} - 6'(j) - 6'd1;
				if (ago >= 6'(NEEDLE_MAX)) begin
					eq = 1'b0;
				end else if (win[ago[IDXW-1:0]] != needle_at(needle_low, needle_high, j)) begin
					eq = 1'b0;
				end
			end
		end
	end

	assign window_eq = eq;

endmodule

[hdl/sf_result.sv]
// ============================================================================
// sf_result - byte count, first match tracking and result register
// Qualifies the window compare, keeps the first match start and loads the
// result register on the last byte of each haystack.
// ============================================================================
module sf_result import sf_pkg::*; #(
	parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
	parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sf_step_t         step,
	input  logic [LEN_W-1:0] needle_len,
	input  logic             window_eq,
	input  logic             out_ready,
	output logic             out_valid,
	output sf_out_t          out_item
);

	localparam int CW = $clog2(HAYSTACK_MAX) + 1;
	localparam int MW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]    cnt_q;
	logic             match_q;
	logic [POS_W-1:0] first_q;
	logic             out_valid_q;
	sf_out_t          out_q;

	logic             hit;
	logic [MW-1:0]    start_w;
	logic [POS_W-1:0] start_sat;
	logic             match_nx;
	logic [POS_W-1:0] first_nx;

	// Qualify the compare: valid length, enough bytes, no earlier match
	always_comb begin
		hit = window_eq && !match_q && (needle_len != '0)
		      && ({1'b0, needle_len} <= 6'(NEEDLE_MAX))
		      && (({1'b0, cnt_q} + (CW+1)'(1)) >= (CW+1)'(needle_len));
		start_w   = MW'(cnt_q) + MW'(1) - MW'(needle_len);
		start_sat = (start_w > MW'(POS_CAP)) ? POS_CAP : start_w[POS_W-1:0];
		match_nx  = match_q || hit;
		first_nx  = hit ? start_sat : first_q;
	end

	// Stream state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
			first_q <= '0;
		end else if (step.fire) begin
			if (step.last_byte) begin
				cnt_q   <= '0;
				match_q <= 1'b0;
				first_q <= '0;
			end else begin
				if (cnt_q < CW'(HAYSTACK_MAX)) begin
					cnt_q <= cnt_q + CW'(1);
				end
				match_q <= match_nx;
				first_q <= first_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.fire && step.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && step.last_byte) begin
			out_q.found          <= match_nx;
			out_q.start_position <= match_nx ? first_nx : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hdl/substring_find.sv]
// ============================================================================
// substring_find - first occurrence of a needle in a streamed haystack
// Byte stream in, one result item per haystack out.
// ============================================================================
// Usage:
//   Write the needle (bytes 0-7, bytes 8-15, length) on the cfg port while
//   the block is idle. Haystack bytes then enter on in_valid/in_ready, one
//   item per byte, last_byte set on the final byte of each haystack.
//   On that byte one result item leaves on out_valid/out_ready: found, and
//   the zero-based start of the first occurrence (0 when not found).
//   Overlapping occurrences are caught; the start saturates at 65535.
// Timing:
//   One byte per cycle sustained while no last byte waits on a stalled
//   result. A last byte passes the input register, then the compare window
//   feeding the result register. The compare is one parallel pass over
//   the window.
// Stall:
//   A waiting result only blocks the next last byte; other bytes keep
//   flowing, and in_ready drops only when a last byte would overwrite it.
// Reset:
//   arst_n clears the needle, the byte count, the match state and both
//   valid flags; the next haystack starts clean.
// ============================================================================
module substring_find import sf_pkg::*; #(
	parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
	parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  sf_in_t           in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output sf_out_t          out_item
);

	logic [CFG_W-1:0] needle_low_q;
	logic [CFG_W-1:0] needle_high_q;
	logic [LEN_W-1:0] needle_len_q;

	logic     s1_valid_q;
	sf_in_t   s1_q;
	logic     s1_fire;
	sf_step_t step;
	logic     window_eq;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				REG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				REG_NEEDLE_LEN:  needle_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage; a last byte waits only while the result register is full and not being taken
	assign s1_fire  = s1_valid_q && (!s1_q.last_byte || !out_valid || out_ready);
	assign in_ready = !s1_valid_q || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_q <= in_item;
		end
	end

	assign step.fire      = s1_fire;
	assign step.last_byte = s1_q.last_byte;
	assign step.data_byte = s1_q.data_byte;

	// Window compare
	sf_window #(
		.NEEDLE_MAX (NEEDLE_MAX)
	) u_window (
		.clk         (clk),
		.step        (step),
		.needle_low  (needle_low_q),
		.needle_high (needle_high_q),
		.needle_len  (needle_len_q),
		.window_eq   (window_eq)
	);

	// Match tracking and result
	sf_result #(
		.NEEDLE_MAX   (NEEDLE_MAX),
		.HAYSTACK_MAX (HAYSTACK_MAX)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.needle_len (needle_len_q),
		.window_eq  (window_eq),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_item   (out_item)
	);

	// A last byte that leaves the input stage always shows up as a result
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && s1_q.last_byte |=> out_valid)
		else $error("last byte processed without a result");

	// Input only backs up behind a last byte and a stalled result
	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid_q && s1_q.last_byte && out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	// A miss reports start position zero
	a_miss_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.start_position == '0)
		else $error("not-found result with nonzero start");

endmodule

[tb/sv/sf_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// sf_checker - result predictor and scoreboard for substring_find
// Watches the configuration port and both item channels. Keeps its own copy
// of the needle, the byte history and the match state. Every accepted
// haystack byte advances the prediction, and every accepted result is
// compared field by field with the oldest predicted one.
// ============================================================================
module sf_checker import sf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  sf_in_t           in_item,
	input  logic             out_valid,
	input  logic             out_ready,
	input  sf_out_t          out_item,
	output int               fail_count,
	output int               pending,
	output int               results_seen,
	output int               hits_seen
);

	localparam int TRAIL_LEN = NEEDLE_MAX_DEF - 1;
	localparam int PRINT_CAP = 40;

	// Shadow of the needle registers
	logic [CFG_W-1:0] needle_lo;
	logic [CFG_W-1:0] needle_hi;
	logic [LEN_W-1:0] needle_len;

	// Stream state: trail[0] is the newest byte before the current one
	logic [7:0]       trail [0:TRAIL_LEN-1];
	logic [16:0]      byte_count;
	logic             match_hit;
	logic [POS_W-1:0] match_start;

	// Predicted results, oldest first
	sf_out_t verdict_q [$];

	// Needle byte j; anything past the two registers is zero
	function automatic logic [7:0] needle_byte(input int j);
		logic [CFG_W-1:0] word;
		if (j >= 16) begin
			return 8'h00;
		end
		word = (j < 8) ? needle_lo : needle_hi;
		word = word >> (8 * (j % 8));
		return word[7:0];
	endfunction

	task automatic clear_stream();
		int k;
		for (k = 0; k < TRAIL_LEN; k++) begin
			trail[k] = 8'h00;
		end
		byte_count  = '0;
		match_hit   = 1'b0;
		match_start = '0;
	endtask

	// One haystack byte: compare the window ending here, shift, count
	task automatic take_byte(input logic [7:0] cur, input logic lst);
		int      len;
		int      idx;
		int      s;
		int      j;
		int      k;
		bit      hit;
		logic [7:0] b;
		sf_out_t res;
		len = needle_len;
		idx = byte_count;
		if (len >= 1 && len <= NEEDLE_MAX_DEF && idx + 1 >= len && !match_hit) begin
			hit = 1'b1;
			for (j = 0; j < len; j++) begin
				if (len - 1 - j == 0) begin
					b = cur;
				end else begin
					b = trail[len - 2 - j];
				end
				if (b != needle_byte(j)) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				s = idx + 1 - len;
				match_hit = 1'b1;
				match_start = (s > POS_CAP) ? POS_CAP : s[POS_W-1:0];
			end
		end
		for (k = TRAIL_LEN - 1; k > 0; k--) begin
			trail[k] = trail[k-1];
		end
		trail[0] = cur;
		if (byte_count < HAYSTACK_MAX_DEF) begin
			byte_count++;
		end
		// last byte closes the haystack with exactly one result
		if (lst) begin
			res.found          = match_hit;
			res.start_position = match_hit ? match_start : '0;
			verdict_q.push_back(res);
			clear_stream();
		end
	endtask

	task automatic check_result(input sf_out_t got);
		sf_out_t want;
		results_seen++;
		if (got.found) begin
			hits_seen++;
		end
		if (verdict_q.size() == 0) begin
			fail_count++;
			if (fail_count <= PRINT_CAP) begin
				$display("%0t ns: result with none expected, got found %0b start %0d",
				         $time, got.found, got.start_position);
			end
			return;
		end
		want = verdict_q.pop_front();
		if (got.found !== want.found) begin
			fail_count++;
			if (fail_count <= PRINT_CAP) begin
				$display("%0t ns: found mismatch, expected %0b, got %0b",
				         $time, want.found, got.found);
			end
		end
		if (got.start_position !== want.start_position) begin
			fail_count++;
			if (fail_count <= PRINT_CAP) begin
				$display("%0t ns: start_position mismatch, expected %0d, got %0d",
				         $time, want.start_position, got.start_position);
			end
		end
	endtask

	// Sample everything at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo  = '0;
			needle_hi  = '0;
			needle_len = '0;
			clear_stream();
			verdict_q.delete();
			pending      = 0;
			fail_count   = 0;
			results_seen = 0;
			hits_seen    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NEEDLE_LOW:  needle_lo  = cfg_data;
					REG_NEEDLE_HIGH: needle_hi  = cfg_data;
					REG_NEEDLE_LEN:  needle_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				take_byte(in_item.data_byte, in_item.last_byte);
			end
			if (out_valid && out_ready) begin
				check_result(out_item);
			end
			pending = verdict_q.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench - stimulus and verdict for substring_find
// Writes a series of needles, from empty through sixteen bytes to lengths
// that can never match, and streams haystacks built mostly from needle
// pieces so that full, partial and overlapping matches are common. Random
// gaps on the input and random stalls on the output.
// ============================================================================
module testbench;
	import sf_pkg::*;

	localparam int RANDOM_BYTES = 550;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = REG_NEEDLE_LOW;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	sf_in_t           in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	sf_out_t          out_item;

	int fail_count;
	int pending;
	int results_seen;
	int hits_seen;

	// Stimulus state
	logic [7:0] pin [0:15];
	logic [7:0] hay [$];
	int         len_now;
	int         bytes_sent = 0;
	int         settings   = 0;
	int         stall_left = 0;
	bit         calm       = 1'b0;

	substring_find dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	sf_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.hits_seen    (hits_seen)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Mostly short gaps, now and then a long one; none while calm
	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Result side stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_needle(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
	                          input logic [CFG_W-1:0] len_word);
		write_reg(REG_NEEDLE_LOW, lo);
		write_reg(REG_NEEDLE_HIGH, hi);
		write_reg(REG_NEEDLE_LEN, len_word);
		settings++;
	endtask

	// One item; returns right after the edge that accepts it
	task automatic send_byte(input logic [7:0] b, input logic lst, input bit rushed);
		int gap;
		gap = rushed ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid          <= 1'b1;
		in_item.data_byte <= b;
		in_item.last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_hay();
		int i;
		calm = ($urandom_range(0, 3) == 0);
		for (i = 0; i < hay.size(); i++) begin
			send_byte(hay[i], i == hay.size() - 1, 1'b0);
		end
	endtask

	// Hold the input until every result is in, then let the pipe drain
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] needle_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hFF;
		end else if (r < 7) begin
			return 8'(8'h41 + $urandom_range(0, 2));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// New needle for a random phase; the first few hit the extremes
	task automatic pick_needle(input int phase);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [CFG_W-1:0] len_word;
		int j;
		int r;
		for (j = 0; j < 16; j++) begin
			pin[j] = needle_pick();
			if (phase == 4) pin[j] = 8'hFF;
			if (phase == 5) pin[j] = 8'h00;
		end
		r = $urandom_range(0, 99);
		case (phase)
			0, 4:    len_now = 16;
			1:       len_now = 1;
			2:       len_now = $urandom_range(17, 31);
			3:       len_now = 0;
			default: begin
				if (r < 5) len_now = 0;
				else if (r < 10) len_now = $urandom_range(17, 31);
				else if (r < 35) len_now = $urandom_range(1, 3);
				else len_now = $urandom_range(1, 16);
			end
		endcase
		for (j = 0; j < 8; j++) begin
			lo[8*j +: 8] = pin[j];
			hi[8*j +: 8] = pin[j+8];
		end
		// unused upper bits of the length word get noise half the time
		len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
		len_word[LEN_W-1:0] = LEN_W'(len_now);
		set_needle(lo, hi, len_word);
	endtask

	// Haystack made of whole needles, needle prefixes, needle bytes, noise
	task automatic build_hay();
		int plen;
		int target;
		int r;
		int j;
		int k;
		plen = (len_now >= 1 && len_now <= 16) ? len_now : 4;
		if ($urandom_range(0, 99) < 88) begin
			target = $urandom_range(1, plen + plen / 2 + 6);
		end else begin
			target = $urandom_range(1, 100);
		end
		hay.delete();
		while (hay.size() < target) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				for (j = 0; j < plen; j++) hay.push_back(pin[j]);
			end else if (r < 5) begin
				k = $urandom_range(1, plen);
				for (j = 0; j < k; j++) hay.push_back(pin[j]);
			end else if (r < 9) begin
				hay.push_back(pin[$urandom_range(0, plen - 1)]);
			end else begin
				hay.push_back(8'($urandom_range(0, 255)));
			end
		end
		while (hay.size() > target) void'(hay.pop_back());
	endtask

	initial begin
		int phase;
		int n;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Empty needle straight out of reset
		hay = '{8'h00, 8'hFF};
		send_hay();
		drain();

		// Overlap: "aab" inside "aaab", then a haystack shorter than the needle
		set_needle(64'h0000_0000_0062_6161, 64'h0, 64'd3);
		hay = '{8'h61, 8'h61, 8'h61, 8'h62};
		send_hay();
		hay = '{8'h61, 8'h61};
		send_hay();
		drain();

		// Single zero byte needle
		set_needle(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
		hay = '{8'hFF, 8'h00};
		send_hay();
		drain();

		// Length above the maximum never matches
		set_needle(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd17);
		hay = '{8'hFF, 8'hFF, 8'hFF};
		send_hay();
		drain();

		// Repeated needle reports the first start
		set_needle(64'h0000_0000_0000_4241, 64'h0, 64'd2);
		hay = '{8'h41, 8'h42, 8'h41, 8'h42};
		send_hay();
		drain();

		// Random phases
		phase = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			pick_needle(phase);
			n = $urandom_range(2, 5);
			repeat (n) begin
				build_hay();
				send_hay();
			end
			drain();
			phase++;
		end
		repeat (8) @(negedge clk);

		$display("Sent %0d haystack bytes under %0d needle settings.",
		         bytes_sent, settings);
		$display("Checked %0d results, %0d of them with a match.", results_seen, hits_seen);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/sf_pkg.sv
hdl/sf_window.sv
hdl/sf_result.sv
hdl/substring_find.sv
tb/sv/sf_checker.sv
tb/sv/testbench.sv
